>>> rtl/scc_pkg.sv
// Package for the strongly convex polygon checker: request and result
// structs, coordinate and determinant widths, cause and direction codes.
// No dependencies.
`default_nettype none

package scc_pkg;

  localparam int FieldBits = 32;
  localparam int CoordBits = 32;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int DetBits   = ProdBits + 1;
  localparam int NumTri    = 3;

  localparam logic [1:0] CauseNone   = 2'd0;
  localparam logic [1:0] CauseTurn   = 2'd1;
  localparam logic [1:0] CauseMinima = 2'd2;
  localparam logic [1:0] CauseDup    = 2'd3;

  localparam logic TurnLeft  = 1'b0;
  localparam logic TurnRight = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [DetBits-1:0]   det_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] point_x;
    logic signed [FieldBits-1:0] point_y;
    logic                        last_point;
  } req_t;

  typedef struct packed {
    logic       is_convex;
    logic [1:0] fail_cause;
  } rsp_t;

  // edge vectors of one triple (a, b, c): b - a and c - a
  typedef struct packed {
    diff_t bax;
    diff_t bay;
    diff_t cax;
    diff_t cay;
  } tri_diff_t;

  // b strictly before a in x-then-y order
  function automatic logic less_xy(coord_t bx, coord_t by, coord_t ax, coord_t ay);
    less_xy = (bx < ax) || ((bx == ax) && (by < ay));
  endfunction

endpackage

`default_nettype wire

>>> rtl/strong_convexity_check_top.sv
// Strongly convex polygon checker, top level.
// Depends on scc_pkg.
`default_nettype none

// Takes one polygon vertex per request and returns one result per polygon,
// on the vertex flagged last_point. Sustains one vertex per clock while no
// result waits; a result passes register stages for edge vectors, products,
// determinant sign and verdict after its last vertex. Each vertex needs up
// to three orientation determinants; six 33x33 multipliers run in parallel
// in the product stage. The whole pipeline stalls only while a result waits.
// turn_direction may be rewritten between polygons or between vertices; a
// vertex is judged with the direction in force when it was taken.
module strong_convexity_check_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_data,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire scc_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output scc_pkg::rsp_t      res
);

  localparam int NumTri = scc_pkg::NumTri;

  logic turn_direction;

  // vertex window
  scc_pkg::coord_t first_x, first_y, second_x, second_y;
  scc_pkg::coord_t older_x, older_y, newer_x, newer_y;
  logic [1:0] seen_count;

  // stage 1
  logic                            s1_valid, s1_fin, s1_dir, s1_dup;
  logic [NumTri-1:0]               s1_on, s1_min;
  scc_pkg::tri_diff_t [NumTri-1:0] s1_d;

  // stage 2
  logic                       s2_valid, s2_fin, s2_dir, s2_dup;
  logic [NumTri-1:0]          s2_on, s2_min;
  scc_pkg::prod_t [NumTri-1:0] s2_p1, s2_p2;

  // polygon accumulators
  logic       turn_failed;
  logic [1:0] minima_count;

  logic en, accept, fin;
  scc_pkg::coord_t px, py;
  scc_pkg::coord_t ax [NumTri];
  scc_pkg::coord_t ay [NumTri];
  scc_pkg::coord_t bx [NumTri];
  scc_pkg::coord_t by [NumTri];
  scc_pkg::coord_t cx [NumTri];
  scc_pkg::coord_t cy [NumTri];
  logic [NumTri-1:0] on_next, min_next_flags;
  scc_pkg::tri_diff_t [NumTri-1:0] d_next;

  scc_pkg::det_t     det [NumTri];
  logic [NumTri-1:0] fail_flags;
  logic              turn_next;
  logic [2:0]        min_sum;
  logic [1:0]        minima_next;
  scc_pkg::rsp_t     res_next;

  assign en        = !(res_valid && !res_ready);
  assign req_ready = en;
  assign accept    = req_valid && req_ready;
  assign fin       = req.last_point;
  assign px        = req.point_x[scc_pkg::CoordBits-1:0];
  assign py        = req.point_y[scc_pkg::CoordBits-1:0];

  // triples: (older, newer, p), (newer, p, first), (p, first, second)
  always_comb begin
    ax[0] = older_x;  ay[0] = older_y;
    bx[0] = newer_x;  by[0] = newer_y;
    cx[0] = px;       cy[0] = py;
    ax[1] = newer_x;  ay[1] = newer_y;
    bx[1] = px;       by[1] = py;
    cx[1] = first_x;  cy[1] = first_y;
    ax[2] = px;       ay[2] = py;
    bx[2] = first_x;  by[2] = first_y;
    cx[2] = second_x; cy[2] = second_y;
    on_next[0] = seen_count[1];
    on_next[1] = seen_count[1] && fin;
    on_next[2] = seen_count[1] && fin;
    for (int i = 0; i < NumTri; i++) begin
      d_next[i].bax = scc_pkg::diff_t'(bx[i]) - scc_pkg::diff_t'(ax[i]);
      d_next[i].bay = scc_pkg::diff_t'(by[i]) - scc_pkg::diff_t'(ay[i]);
      d_next[i].cax = scc_pkg::diff_t'(cx[i]) - scc_pkg::diff_t'(ax[i]);
      d_next[i].cay = scc_pkg::diff_t'(cy[i]) - scc_pkg::diff_t'(ay[i]);
      min_next_flags[i] = on_next[i]
                          && scc_pkg::less_xy(bx[i], by[i], ax[i], ay[i])
                          && scc_pkg::less_xy(bx[i], by[i], cx[i], cy[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_direction <= scc_pkg::TurnLeft;
    end else if (cfg_we) begin
      turn_direction <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= 2'd0;
    end else if (accept) begin
      if (fin) begin
        seen_count <= 2'd0;
      end else if (seen_count != 2'd3) begin
        seen_count <= seen_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_count == 2'd0) begin
        first_x <= px;
        first_y <= py;
      end
      if (seen_count == 2'd1) begin
        second_x <= px;
        second_y <= py;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= px;
      newer_y <= py;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= req_valid;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid && s2_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fin <= fin;
      s1_dir <= turn_direction;
      s1_dup <= (seen_count == 2'd1) && fin && (first_x == px) && (first_y == py);
      s1_on  <= on_next;
      s1_min <= min_next_flags;
      s1_d   <= d_next;

      s2_fin <= s1_fin;
      s2_dir <= s1_dir;
      s2_dup <= s1_dup;
      s2_on  <= s1_on;
      s2_min <= s1_min;
      for (int i = 0; i < NumTri; i++) begin
        s2_p1[i] <= scc_pkg::prod_t'(s1_d[i].bax) * scc_pkg::prod_t'(s1_d[i].cay);
        s2_p2[i] <= scc_pkg::prod_t'(s1_d[i].bay) * scc_pkg::prod_t'(s1_d[i].cax);
      end

      res <= res_next;
    end
  end

  // determinant sign and verdict
  always_comb begin
    for (int i = 0; i < NumTri; i++) begin
      det[i] = scc_pkg::det_t'(s2_p1[i]) - scc_pkg::det_t'(s2_p2[i]);
      if (s2_dir == scc_pkg::TurnLeft) begin
        fail_flags[i] = s2_on[i] && (det[i][scc_pkg::DetBits-1] || (det[i] == '0));
      end else begin
        fail_flags[i] = s2_on[i] && !det[i][scc_pkg::DetBits-1];
      end
    end
    turn_next   = turn_failed || (|fail_flags);
    min_sum     = {1'b0, minima_count} + 3'(s2_min[0]) + 3'(s2_min[1]) + 3'(s2_min[2]);
    minima_next = (min_sum >= 3'd2) ? 2'd2 : min_sum[1:0];
    if (s2_dup) begin
      res_next = '{is_convex: 1'b0, fail_cause: scc_pkg::CauseDup};
    end else if (turn_next) begin
      res_next = '{is_convex: 1'b0, fail_cause: scc_pkg::CauseTurn};
    end else if (minima_next == 2'd2) begin
      res_next = '{is_convex: 1'b0, fail_cause: scc_pkg::CauseMinima};
    end else begin
      res_next = '{is_convex: 1'b1, fail_cause: scc_pkg::CauseNone};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_failed  <= 1'b0;
      minima_count <= 2'd0;
    end else if (en && s2_valid) begin
      if (s2_fin) begin
        turn_failed  <= 1'b0;
        minima_count <= 2'd0;
      end else begin
        turn_failed  <= turn_next;
        minima_count <= minima_next;
      end
    end
  end

  a_minima_sat: assert property (@(posedge clk) disable iff (rst)
    minima_count != 2'd3)
    else $error("minima count past saturation");

  a_verdict_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.is_convex == (res.fail_cause == scc_pkg::CauseNone)))
    else $error("verdict and cause disagree");

  a_new_polygon: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> seen_count == 2'd0)
    else $error("window not restarted after last vertex");

  a_seen_step: assert property (@(posedge clk) disable iff (rst)
    accept && !fin && seen_count != 2'd3 |=> seen_count == $past(seen_count) + 2'd1)
    else $error("vertex count did not advance");

  a_dup_two_only: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_dup |-> s1_fin && (s1_on == '0))
    else $error("duplicate flag outside a two-vertex polygon");

endmodule

`default_nettype wire

>>> sim/strong_convexity_check_top_tb.sv
// Testbench for strong_convexity_check_top: streams polygons, predicts each
// verdict in a local model, checks results in order. Depends on scc_pkg and
// the checker RTL.
`timescale 1ns / 100ps

module strong_convexity_check_top_tb;

  localparam int              RxHoldCycles = 300;
  localparam int              SettleCycles = 6;
  localparam scc_pkg::coord_t CoordMin     = {1'b1, {(scc_pkg::CoordBits-1){1'b0}}};
  localparam scc_pkg::coord_t CoordMax     = {1'b0, {(scc_pkg::CoordBits-1){1'b1}}};

  typedef logic signed [67:0] wide_t;
  typedef struct {
    scc_pkg::coord_t x;
    scc_pkg::coord_t y;
  } vtx_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cfg_we    = 1'b0;
  logic          cfg_data  = 1'b0;
  logic          req_valid = 1'b0;
  logic          req_ready;
  scc_pkg::req_t req       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  scc_pkg::rsp_t res;

  // local copy of the checker state
  logic            turn_dir;
  scc_pkg::coord_t head_x, head_y, next_x, next_y;
  scc_pkg::coord_t win_prev_x, win_prev_y, win_last_x, win_last_y;
  logic [1:0]      vertex_cnt;
  logic            turn_bad;
  logic [1:0]      minima_cnt;

  scc_pkg::rsp_t verdicts[$];
  vtx_t outline[$];
  int   ring_x[16] = '{10, 9, 7, 4, 0, -4, -7, -9, -10, -9, -7, -4, 0, 4, 7, 9};
  int   errs       = 0;
  int   items_sent = 0;
  bit   tx_idle_en = 1'b0;
  bit   rx_idle_en = 1'b0;
  bit   rx_hold_req = 1'b0;

  strong_convexity_check_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int turn_sign(input scc_pkg::coord_t ax, ay, bx, by, cx, cy);
    wide_t det;
    det = (wide_t'(bx) - wide_t'(ax)) * (wide_t'(cy) - wide_t'(ay))
        - (wide_t'(by) - wide_t'(ay)) * (wide_t'(cx) - wide_t'(ax));
    if (det == '0) return 0;
    return det[67] ? -1 : 1;
  endfunction

  function automatic bit lex_before(input scc_pkg::coord_t bx, by, ax, ay);
    return (bx < ax) || ((bx == ax) && (by < ay));
  endfunction

  task automatic score_triple(input scc_pkg::coord_t ax, ay, bx, by, cx, cy);
    int want;
    want = (turn_dir == scc_pkg::TurnRight) ? -1 : 1;
    if (turn_sign(ax, ay, bx, by, cx, cy) != want) turn_bad = 1'b1;
    if (lex_before(bx, by, ax, ay) && lex_before(bx, by, cx, cy) && minima_cnt < 2'd2)
      minima_cnt = minima_cnt + 2'd1;
  endtask

  task automatic judge_vertex(input scc_pkg::req_t r);
    scc_pkg::coord_t px, py;
    scc_pkg::rsp_t   v;
    px = r.point_x;
    py = r.point_y;
    v.is_convex  = 1'b1;
    v.fail_cause = scc_pkg::CauseNone;
    if (vertex_cnt == 2'd0) begin
      head_x = px;
      head_y = py;
    end else if (vertex_cnt == 2'd1) begin
      next_x = px;
      next_y = py;
      if (r.last_point && head_x == px && head_y == py) begin
        v.is_convex  = 1'b0;
        v.fail_cause = scc_pkg::CauseDup;
      end
    end else begin
      score_triple(win_prev_x, win_prev_y, win_last_x, win_last_y, px, py);
      if (r.last_point) begin
        score_triple(win_last_x, win_last_y, px, py, head_x, head_y);
        score_triple(px, py, head_x, head_y, next_x, next_y);
        if (turn_bad) begin
          v.is_convex  = 1'b0;
          v.fail_cause = scc_pkg::CauseTurn;
        end else if (minima_cnt > 2'd1) begin
          v.is_convex  = 1'b0;
          v.fail_cause = scc_pkg::CauseMinima;
        end
      end
    end
    win_prev_x = win_last_x;
    win_prev_y = win_last_y;
    win_last_x = px;
    win_last_y = py;
    if (vertex_cnt < 2'd3) vertex_cnt = vertex_cnt + 2'd1;
    if (r.last_point) begin
      verdicts.push_back(v);
      vertex_cnt = 2'd0;
      turn_bad   = 1'b0;
      minima_cnt = 2'd0;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    scc_pkg::rsp_t exp_v;
    if (!rst && res_valid && res_ready) begin
      if (verdicts.size() == 0) begin
        $error("result with no request pending: is_convex %0d fail_cause %0d",
               res.is_convex, res.fail_cause);
        errs++;
      end else begin
        exp_v = verdicts.pop_front();
        if (res.is_convex !== exp_v.is_convex) begin
          $error("is_convex: expected %0d, got %0d", exp_v.is_convex, res.is_convex);
          errs++;
        end
        if (res.fail_cause !== exp_v.fail_cause) begin
          $error("fail_cause: expected %0d, got %0d", exp_v.fail_cause, res.fail_cause);
          errs++;
        end
      end
    end
  end

  // result side ready: random stalls plus an on-demand long hold
  always begin
    @(posedge clk);
    if (rx_hold_req) begin
      res_ready <= 1'b0;
      repeat (RxHoldCycles) @(posedge clk);
      rx_hold_req = 1'b0;
      res_ready <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      res_ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      res_ready <= 1'b1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // valid is left high after a request is taken; callers that pause use settle
  task automatic send_point(input scc_pkg::coord_t x, input scc_pkg::coord_t y,
                            input logic last);
    scc_pkg::req_t r;
    r.point_x    = x;
    r.point_y    = y;
    r.last_point = last;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    judge_vertex(r);
    items_sent++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_turn(input logic dir);
    cfg_we   <= 1'b1;
    cfg_data <= dir;
    @(posedge clk);
    turn_dir = dir;
    cfg_we   <= 1'b0;
  endtask

  task automatic send_outline();
    for (int i = 0; i < outline.size(); i++)
      send_point(outline[i].x, outline[i].y, i == outline.size() - 1);
  endtask

  // subset of a strictly convex 16-gon, random start, scale and offset
  task automatic build_ring(input int n, input bit cw);
    bit [15:0] keep;
    int        cnt, k, idx, scale, ox, oy;
    vtx_t      p;
    keep  = '1;
    cnt   = 16;
    scale = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 26)
                                        : $urandom_range(1, 1 << 16);
    ox    = int'($urandom) >>> 2;
    oy    = int'($urandom) >>> 2;
    while (cnt > n) begin
      k = $urandom_range(0, 15);
      if (keep[k]) begin
        keep[k] = 1'b0;
        cnt--;
      end
    end
    k = $urandom_range(0, 15);
    outline.delete();
    for (int i = 0; i < 16; i++) begin
      idx = cw ? (k - i + 16) % 16 : (k + i) % 16;
      if (keep[idx]) begin
        p.x = ox + scale * ring_x[idx];
        p.y = oy + scale * ring_x[(idx + 12) % 16];
        outline.push_back(p);
      end
    end
  endtask

  task automatic random_polygon();
    int   kind, n, m;
    bit   cw;
    vtx_t p;
    kind = $urandom_range(0, 99);
    cw   = (turn_dir == scc_pkg::TurnRight);
    n    = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 16) : $urandom_range(3, 6);
    if (kind < 55) begin
      build_ring(n, cw);
    end else if (kind < 65) begin
      build_ring(n, !cw);
    end else if (kind < 73) begin
      build_ring(n, cw);
      m = outline.size();
      for (int i = 0; i < m; i++) outline.push_back(outline[i]);
    end else if (kind < 83) begin
      build_ring(n, cw);
      m = $urandom_range(0, outline.size() - 1);
      if ($urandom_range(0, 1)) begin
        outline[m].x = scc_pkg::coord_t'($urandom);
        outline[m].y = scc_pkg::coord_t'($urandom);
      end else begin
        outline[m] = outline[(m + 1) % outline.size()];
      end
    end else if (kind < 93) begin
      outline.delete();
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        p.x = scc_pkg::coord_t'($urandom);
        p.y = scc_pkg::coord_t'($urandom);
        outline.push_back(p);
      end
    end else begin
      outline.delete();
      p.x = scc_pkg::coord_t'($urandom);
      p.y = scc_pkg::coord_t'($urandom);
      outline.push_back(p);
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1)) p.y = p.y + 1;
        outline.push_back(p);
      end
    end
    send_outline();
  endtask

  task automatic test_small_polygons();
    send_point(CoordMin, CoordMax, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
  endtask

  task automatic test_turns();
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(CoordMax, CoordMax, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(3, 3, 1'b0);
    send_point(-7, -7, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(0, 1, 1'b0);
    send_point(1, 0, 1'b1);
  endtask

  // doubly wound triangles: two minima, then two minima plus bad turns
  task automatic test_minima();
    for (int i = 0; i < 2; i++) begin
      send_point(0, 0, 1'b0);
      send_point(4, 0, 1'b0);
      send_point(0, 4, i == 1);
    end
    for (int i = 0; i < 2; i++) begin
      send_point(0, 0, 1'b0);
      send_point(0, 4, 1'b0);
      send_point(4, 0, i == 1);
    end
  endtask

  task automatic test_direction();
    settle();
    write_turn(scc_pkg::TurnRight);
    send_point(0, 0, 1'b0);
    send_point(0, 4, 1'b0);
    send_point(4, 0, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(0, 4, 1'b0);
    send_point(4, 4, 1'b0);
    settle();
    write_turn(scc_pkg::TurnLeft);
    send_point(4, 0, 1'b1);
    settle();
  endtask

  task automatic test_random(input logic dir, input int count);
    int start;
    settle();
    write_turn(dir);
    start = items_sent;
    while (items_sent - start < count) random_polygon();
  endtask

  task automatic test_backpressure(input int count);
    int start;
    settle();
    rx_hold_req = 1'b1;
    start = items_sent;
    while (items_sent - start < count) random_polygon();
    settle();
  endtask

  initial begin
    turn_dir   = scc_pkg::TurnLeft;
    vertex_cnt = 2'd0;
    turn_bad   = 1'b0;
    minima_cnt = 2'd0;
    {head_x, head_y, next_x, next_y} = '0;
    {win_prev_x, win_prev_y, win_last_x, win_last_y} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_turn(scc_pkg::TurnLeft);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_small_polygons();
    test_turns();
    test_minima();
    test_direction();
    test_random(scc_pkg::TurnLeft, 170);
    test_backpressure(40);
    test_random(scc_pkg::TurnRight, 150);
    settle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(scc_pkg::TurnLeft, 150);
    settle();
    if (errs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
